>>> sv/rtrap_pkg.sv
// Shared types and constants for the trap entry and interrupt select block.
// Used by rtrap_irq_pick and riscv_trap_entry_and_interrupt_select; no dependencies.
`default_nettype none
package rtrap_pkg;

    localparam int XLEN = 64;
    localparam int IRQ_W = 12;
    localparam int EXC_W = 16;
    localparam int CAUSE_W = 4;
    localparam int IRQ_PRIO_N = 6;

    // Command codes.
    localparam logic CMD_EXCEPTION = 1'b0;
    localparam logic CMD_IRQ_CHECK = 1'b1;

    // Privilege codes.
    localparam logic [1:0] MODE_USER = 2'd0;
    localparam logic [1:0] MODE_SUPER = 2'd1;
    localparam logic [1:0] MODE_RESERVED = 2'd2;
    localparam logic [1:0] MODE_MACHINE = 2'd3;

    // Vector mode field of a trap vector base.
    localparam logic [1:0] VEC_VECTORED = 2'd1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_EXC_DELEG = 2'd0;
    localparam logic [1:0] CFG_IRQ_DELEG = 2'd1;
    localparam logic [1:0] CFG_MTVEC = 2'd2;
    localparam logic [1:0] CFG_STVEC = 2'd3;

    // Supervisor interrupt bits: software, timer and external.
    localparam logic [IRQ_W-1:0] SUPER_IRQ_MASK = 12'h222;

    // Interrupt priority, highest first.
    localparam logic [CAUSE_W-1:0] IRQ_ORDER [IRQ_PRIO_N] = '{
        4'd11, 4'd3, 4'd7, 4'd9, 4'd1, 4'd5
    };

    typedef struct packed {
        logic             command;
        logic [1:0]       current_mode;
        logic             machine_int_enable;
        logic             super_int_enable;
        logic [XLEN-1:0]  trap_pc;
        logic [3:0]       exc_cause;
        logic [XLEN-1:0]  exc_value;
        logic [IRQ_W-1:0] irq_pending;
        logic [IRQ_W-1:0] irq_enable;
    } t_trap_in;

    typedef struct packed {
        logic            trap_taken;
        logic            to_supervisor;
        logic [1:0]      next_mode;
        logic [XLEN-1:0] next_pc;
        logic [XLEN-1:0] cause_word;
        logic [XLEN-1:0] trap_value_out;
        logic [XLEN-1:0] saved_pc;
        logic            saved_int_enable;
        logic [1:0]      saved_mode;
    } t_trap_out;

    typedef struct packed {
        logic               found;
        logic [CAUSE_W-1:0] cause;
    } t_irq_sel;

endpackage
`default_nettype wire

>>> sv/rtrap_irq_pick.sv
// Priority selection of one interrupt from the machine and supervisor candidates.
// Depends on rtrap_pkg for the priority order and the selection struct.
`default_nettype none
module rtrap_irq_pick
    import rtrap_pkg::*;
(
    input  wire logic [IRQ_W-1:0] i_m_cand,
    input  wire logic [IRQ_W-1:0] i_s_cand,
    output t_irq_sel              o_sel
);

    t_irq_sel m_sel;
    t_irq_sel s_sel;

    // Walk the order from lowest to highest priority so the highest one wins.
    always_comb begin
        m_sel = '0;
        s_sel = '0;
        for (int i = IRQ_PRIO_N - 1; i >= 0; i--) begin
            if (i_m_cand[IRQ_ORDER[i]]) begin
                m_sel.found = 1'b1;
                m_sel.cause = IRQ_ORDER[i];
            end
            if (i_s_cand[IRQ_ORDER[i]]) begin
                s_sel.found = 1'b1;
                s_sel.cause = IRQ_ORDER[i];
            end
        end
    end

    // Machine candidates are considered before supervisor ones.
    assign o_sel = m_sel.found ? m_sel : s_sel;

endmodule
`default_nettype wire

>>> sv/riscv_trap_entry_and_interrupt_select.sv
// Top level of trap entry with M/S delegation and interrupt selection.
// Depends on rtrap_pkg and instantiates rtrap_irq_pick.
`default_nettype none
//
//  Channel   Handshake            Word
//  --------  -------------------  ----------------------------------------
//  input     start, busy          i_item   (t_trap_in)
//  result    o_done strobe        o_result (t_trap_out), one cycle only
//  config    i_cfg_we             i_cfg_idx, i_cfg_data
//
//  One word may enter every cycle; busy is always low. Each word gives one
//  result, registered at the end of each stage: stage one masks the
//  candidate interrupts, stage two picks the cause and delegation, stage
//  three forms the handler address with its 64-bit add. Synchronous reset
//  clears the valid bits and the configuration registers. The receiver
//  cannot stall, so nothing is held back.
//
module riscv_trap_entry_and_interrupt_select
    import rtrap_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire t_trap_in        i_item,
    output logic                 o_done,
    output t_trap_out            o_result,
    input  wire logic            i_cfg_we,
    input  wire logic [1:0]      i_cfg_idx,
    input  wire logic [XLEN-1:0] i_cfg_data
);

    // Configuration registers.
    logic [EXC_W-1:0] r_exc_deleg;
    logic [IRQ_W-1:0] r_irq_deleg;
    logic [XLEN-1:0]  r_mtvec;
    logic [XLEN-1:0]  r_stvec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exc_deleg <= '0;
            r_irq_deleg <= '0;
            r_mtvec     <= '0;
            r_stvec     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_EXC_DELEG: r_exc_deleg <= i_cfg_data[EXC_W-1:0];
                CFG_IRQ_DELEG: r_irq_deleg <= i_cfg_data[IRQ_W-1:0];
                CFG_MTVEC:     r_mtvec     <= i_cfg_data;
                CFG_STVEC:     r_stvec     <= i_cfg_data;
                default:       r_mtvec     <= r_mtvec;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage one: global enables and candidate masks.
    logic             n_m_en;
    logic             n_s_en;
    logic [IRQ_W-1:0] n_act;
    logic [IRQ_W-1:0] n_m_cand;
    logic [IRQ_W-1:0] n_s_cand;

    always_comb begin
        n_act    = i_item.irq_pending & i_item.irq_enable;
        n_m_en   = (i_item.current_mode == MODE_MACHINE) ? i_item.machine_int_enable : 1'b1;
        n_s_en   = (i_item.current_mode == MODE_SUPER) ? i_item.super_int_enable
                                                       : (i_item.current_mode == MODE_USER);
        n_m_cand = n_m_en ? (n_act & ~r_irq_deleg) : '0;
        n_s_cand = n_s_en ? (n_act & r_irq_deleg & SUPER_IRQ_MASK) : '0;
    end

    logic             r_s1_valid;
    logic             r_s1_is_int;
    logic [1:0]       r_s1_mode;
    logic             r_s1_mie;
    logic             r_s1_sie;
    logic [XLEN-1:0]  r_s1_pc;
    logic [3:0]       r_s1_cause;
    logic [XLEN-1:0]  r_s1_tval;
    logic [IRQ_W-1:0] r_s1_m_cand;
    logic [IRQ_W-1:0] r_s1_s_cand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_is_int <= (i_item.command == CMD_IRQ_CHECK);
        r_s1_mode   <= i_item.current_mode;
        r_s1_mie    <= i_item.machine_int_enable;
        r_s1_sie    <= i_item.super_int_enable;
        r_s1_pc     <= i_item.trap_pc;
        r_s1_cause  <= i_item.exc_cause;
        r_s1_tval   <= i_item.exc_value;
        r_s1_m_cand <= n_m_cand;
        r_s1_s_cand <= n_s_cand;
    end

    // Stage two: pick the interrupt, decide the delegation.
    t_irq_sel           sel;
    logic               n_taken;
    logic [CAUSE_W-1:0] n_cause;
    logic               n_deleg;
    logic [EXC_W-1:0]   irq_deleg_ext;

    rtrap_irq_pick u_pick (
        .i_m_cand (r_s1_m_cand),
        .i_s_cand (r_s1_s_cand),
        .o_sel    (sel)
    );

    always_comb begin
        irq_deleg_ext = {{(EXC_W - IRQ_W){1'b0}}, r_irq_deleg};
        n_taken       = !r_s1_is_int || sel.found;
        n_cause       = r_s1_is_int ? sel.cause : r_s1_cause;
        n_deleg       = (r_s1_mode != MODE_MACHINE) &&
                        (r_s1_is_int ? irq_deleg_ext[n_cause] : r_exc_deleg[n_cause]);
    end

    logic               r_s2_valid;
    logic               r_s2_taken;
    logic               r_s2_is_int;
    logic               r_s2_deleg;
    logic [CAUSE_W-1:0] r_s2_cause;
    logic [1:0]         r_s2_mode;
    logic               r_s2_mie;
    logic               r_s2_sie;
    logic [XLEN-1:0]    r_s2_pc;
    logic [XLEN-1:0]    r_s2_tval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_taken  <= n_taken;
        r_s2_is_int <= r_s1_is_int;
        r_s2_deleg  <= n_deleg;
        r_s2_cause  <= n_cause;
        r_s2_mode   <= r_s1_mode;
        r_s2_mie    <= r_s1_mie;
        r_s2_sie    <= r_s1_sie;
        r_s2_pc     <= r_s1_pc;
        r_s2_tval   <= r_s1_is_int ? '0 : r_s1_tval;
    end

    // Stage three: handler address and the result word.
    logic [XLEN-1:0] vec;
    logic [XLEN-1:0] offset;
    t_trap_out       n_result;

    always_comb begin
        vec    = r_s2_deleg ? r_stvec : r_mtvec;
        // Vectored entry adds four times the cause, for interrupts only.
        offset = (r_s2_is_int && vec[1:0] == VEC_VECTORED)
               ? {{(XLEN - CAUSE_W - 2){1'b0}}, r_s2_cause, 2'b00} : '0;
        n_result = '0;
        if (r_s2_taken) begin
            n_result.trap_taken       = 1'b1;
            n_result.to_supervisor    = r_s2_deleg;
            n_result.next_mode        = r_s2_deleg ? MODE_SUPER : MODE_MACHINE;
            n_result.next_pc          = {vec[XLEN-1:2], 2'b00} + offset;
            n_result.cause_word       = {r_s2_is_int, {(XLEN - 1 - CAUSE_W){1'b0}}, r_s2_cause};
            n_result.trap_value_out   = r_s2_tval;
            n_result.saved_pc         = r_s2_pc;
            n_result.saved_int_enable = r_s2_deleg ? r_s2_sie : r_s2_mie;
            n_result.saved_mode       = r_s2_deleg ? {1'b0, (r_s2_mode != MODE_USER)}
                                                   : r_s2_mode;
        end
    end

    logic      r_done;
    t_trap_out r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for riscv_trap_entry_and_interrupt_select.
// Depends on rtrap_pkg; predicts every trap decision and checks each result word in order.
module tb
    import rtrap_pkg::*;
();

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    t_trap_in        i_item;
    logic            o_done;
    t_trap_out       o_result;
    logic            i_cfg_we;
    logic [1:0]      i_cfg_idx;
    logic [XLEN-1:0] i_cfg_data;

    // Interrupt priority, highest first.
    localparam logic [CAUSE_W-1:0] IRQ_RANK [IRQ_PRIO_N] = '{
        4'd11, 4'd3, 4'd7, 4'd9, 4'd1, 4'd5
    };

    // Copies of the configuration registers as the block should hold them.
    logic [EXC_W-1:0] medeleg_copy;
    logic [IRQ_W-1:0] mideleg_copy;
    logic [XLEN-1:0]  mtvec_copy;
    logic [XLEN-1:0]  stvec_copy;

    t_trap_out trap_decisions_q[$];
    int        error_count = 0;
    int        burst_left = 0;

    riscv_trap_entry_and_interrupt_select DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic highest_irq(input logic [IRQ_W-1:0] cand,
                                         output logic [CAUSE_W-1:0] cause);
        cause = '0;
        foreach (IRQ_RANK[i]) begin
            if (cand[IRQ_RANK[i]]) begin
                cause = IRQ_RANK[i];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_trap_out decide_trap(input t_trap_in w);
        t_trap_out          r;
        logic [IRQ_W-1:0]   act;
        logic [CAUSE_W-1:0] cause;
        logic [XLEN-1:0]    tval;
        logic [XLEN-1:0]    vec;
        logic [XLEN-1:0]    offset;
        logic               is_int;
        logic               m_en;
        logic               s_en;
        logic               found;
        logic               deleg;
        r = '0;
        is_int = (w.command == CMD_IRQ_CHECK);
        cause = w.exc_cause;
        tval = w.exc_value;
        found = 1'b0;
        deleg = 1'b0;
        if (is_int) begin
            act = w.irq_pending & w.irq_enable;
            m_en = (w.current_mode == MODE_MACHINE) ? w.machine_int_enable : 1'b1;
            s_en = (w.current_mode == MODE_SUPER) ? w.super_int_enable
                                                  : (w.current_mode == MODE_USER);
            if (m_en)
                found = highest_irq(act & ~mideleg_copy, cause);
            if (!found && s_en)
                found = highest_irq(act & mideleg_copy & SUPER_IRQ_MASK, cause);
            // With nothing taken the whole word stays zero.
            if (!found)
                return r;
            tval = '0;
        end
        if (w.current_mode != MODE_MACHINE)
            deleg = is_int ? mideleg_copy[cause] : medeleg_copy[cause];
        vec = deleg ? stvec_copy : mtvec_copy;
        offset = (is_int && vec[1:0] == VEC_VECTORED) ? {58'd0, cause, 2'b00} : '0;
        r.trap_taken       = 1'b1;
        r.to_supervisor    = deleg;
        r.next_mode        = deleg ? MODE_SUPER : MODE_MACHINE;
        r.next_pc          = {vec[XLEN-1:2], 2'b00} + offset;
        r.cause_word       = {is_int, 59'd0, cause};
        r.trap_value_out   = tval;
        r.saved_pc         = w.trap_pc;
        r.saved_int_enable = deleg ? w.super_int_enable : w.machine_int_enable;
        r.saved_mode       = deleg ? {1'b0, w.current_mode != MODE_USER} : w.current_mode;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // Tracks register writes and accepted words, and checks each result word.
    always @(posedge i_clk) begin
        t_trap_out want;
        if (!i_rst_n) begin
            medeleg_copy = '0;
            mideleg_copy = '0;
            mtvec_copy   = '0;
            stvec_copy   = '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_EXC_DELEG: medeleg_copy = i_cfg_data[EXC_W-1:0];
                    CFG_IRQ_DELEG: mideleg_copy = i_cfg_data[IRQ_W-1:0];
                    CFG_MTVEC:     mtvec_copy   = i_cfg_data;
                    CFG_STVEC:     stvec_copy   = i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                trap_decisions_q.push_back(decide_trap(i_item));
            if (o_done === 1'b1) begin
                if (trap_decisions_q.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = trap_decisions_q.pop_front();
                    check_field("trap_taken", 64'(o_result.trap_taken),
                                64'(want.trap_taken));
                    check_field("to_supervisor", 64'(o_result.to_supervisor),
                                64'(want.to_supervisor));
                    check_field("next_mode", 64'(o_result.next_mode), 64'(want.next_mode));
                    check_field("next_pc", o_result.next_pc, want.next_pc);
                    check_field("cause_word", o_result.cause_word, want.cause_word);
                    check_field("trap_value_out", o_result.trap_value_out,
                                want.trap_value_out);
                    check_field("saved_pc", o_result.saved_pc, want.saved_pc);
                    check_field("saved_int_enable", 64'(o_result.saved_int_enable),
                                64'(want.saved_int_enable));
                    check_field("saved_mode", 64'(o_result.saved_mode),
                                64'(want.saved_mode));
                end
            end
        end
    end

    function automatic t_trap_in make_word(input logic cmd, input logic [1:0] mode,
                                           input logic mie, input logic sie,
                                           input logic [63:0] pc, input logic [3:0] cause,
                                           input logic [63:0] val,
                                           input logic [IRQ_W-1:0] ip,
                                           input logic [IRQ_W-1:0] ie);
        t_trap_in w;
        w.command            = cmd;
        w.current_mode       = mode;
        w.machine_int_enable = mie;
        w.super_int_enable   = sie;
        w.trap_pc            = pc;
        w.exc_cause          = cause;
        w.exc_value          = val;
        w.irq_pending        = ip;
        w.irq_enable         = ie;
        return w;
    endfunction

    function automatic logic [IRQ_W-1:0] random_irq_bits();
        case ($urandom_range(0, 3))
            0: return 12'd1 << $urandom_range(0, IRQ_W - 1);
            1: return '1;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic t_trap_in random_word();
        t_trap_in w;
        w.command            = 1'($urandom_range(0, 1));
        w.current_mode       = 2'($urandom_range(0, 3));
        w.machine_int_enable = 1'($urandom_range(0, 1));
        w.super_int_enable   = 1'($urandom_range(0, 1));
        w.trap_pc            = {$urandom, $urandom};
        w.exc_cause          = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 7))
            0: w.exc_value = '0;
            1: w.exc_value = '1;
            default: w.exc_value = {$urandom, $urandom};
        endcase
        w.irq_pending        = random_irq_bits();
        w.irq_enable         = random_irq_bits();
        return w;
    endfunction

    // Sends one word; the sender may pause between bursts of random length.
    task automatic send_word(input t_trap_in w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        end
        start  <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy);
        burst_left--;
    endtask

    task automatic drain();
        start <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (trap_decisions_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [XLEN-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Must only be called with the block idle.
    task automatic set_config(input logic [63:0] exc_d, input logic [63:0] irq_d,
                              input logic [63:0] mvec, input logic [63:0] svec);
        write_reg(CFG_EXC_DELEG, exc_d);
        write_reg(CFG_IRQ_DELEG, irq_d);
        write_reg(CFG_MTVEC, mvec);
        write_reg(CFG_STVEC, svec);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_state();
        send_word(make_word(CMD_EXCEPTION, MODE_USER, 1'b0, 1'b0, '0, 4'd0, '0, '0, '0));
        send_word(make_word(CMD_IRQ_CHECK, MODE_MACHINE, 1'b1, 1'b0, 64'h1000, 4'd0,
                            64'h55, 12'hFFF, 12'hFFF));
    endtask

    task automatic test_full_delegation();
        drain();
        // Every cause delegated; supervisor base is vectored, machine base is all ones.
        set_config('1, '1, '1, 64'h0000_0000_8000_0001);
        send_word(make_word(CMD_EXCEPTION, MODE_USER, 1'b1, 1'b0, '1, 4'd15, '1, '0, '0));
        send_word(make_word(CMD_EXCEPTION, MODE_MACHINE, 1'b0, 1'b1, '1, 4'd15, '1, '0, '0));
        send_word(make_word(CMD_EXCEPTION, MODE_RESERVED, 1'b1, 1'b1, 64'h20, 4'd5, 64'h7,
                            '0, '0));
        send_word(make_word(CMD_IRQ_CHECK, MODE_USER, 1'b0, 1'b0, 64'h40, 4'd0, '1,
                            12'hFFF, 12'hFFF));
        send_word(make_word(CMD_IRQ_CHECK, MODE_MACHINE, 1'b1, 1'b1, 64'h44, 4'd0, '0,
                            12'hFFF, 12'hFFF));
        send_word(make_word(CMD_IRQ_CHECK, MODE_SUPER, 1'b1, 1'b0, 64'h48, 4'd0, '0,
                            12'hFFF, 12'hFFF));
        send_word(make_word(CMD_IRQ_CHECK, MODE_SUPER, 1'b0, 1'b1, 64'h4C, 4'd0, '0,
                            12'h020, 12'hFFF));
        send_word(make_word(CMD_IRQ_CHECK, MODE_RESERVED, 1'b1, 1'b1, 64'h50, 4'd0, '0,
                            12'hFFF, 12'hFFF));
        // A delegated bit outside the supervisor set is never taken.
        send_word(make_word(CMD_IRQ_CHECK, MODE_USER, 1'b1, 1'b1, 64'h54, 4'd0, '0,
                            12'h800, 12'h800));
    endtask

    task automatic test_interrupt_priority();
        drain();
        set_config(64'hAAAA, 64'h222, 64'h8000_0000_0000_1001, 64'h4000_0000_0000_2002);
        foreach (IRQ_RANK[i])
            send_word(make_word(CMD_IRQ_CHECK, MODE_USER, 1'b0, 1'b1, 64'h100 + 64'(i),
                                4'd0, '1, 12'd1 << IRQ_RANK[i], 12'd1 << IRQ_RANK[i]));
        send_word(make_word(CMD_IRQ_CHECK, MODE_MACHINE, 1'b0, 1'b1, 64'h200, 4'd0, '0,
                            12'hFFF, 12'hFFF));
        // Only bits that have no priority slot are pending.
        send_word(make_word(CMD_IRQ_CHECK, MODE_SUPER, 1'b0, 1'b1, 64'h204, 4'd0, '0,
                            12'h555, 12'hFFF));
        send_word(make_word(CMD_IRQ_CHECK, MODE_USER, 1'b1, 1'b1, 64'h208, 4'd0, '0,
                            12'hFFF, 12'h000));
        // Vectored machine base, but an exception gets no offset.
        send_word(make_word(CMD_EXCEPTION, MODE_MACHINE, 1'b1, 1'b0, 64'h20C, 4'd3,
                            64'h33, '0, '0));
        send_word(make_word(CMD_EXCEPTION, MODE_SUPER, 1'b1, 1'b0, 64'h210, 4'd4,
                            64'h44, '0, '0));
        send_word(make_word(CMD_IRQ_CHECK, MODE_RESERVED, 1'b0, 1'b1, 64'h214, 4'd0, '0,
                            12'h888, 12'h888));
    endtask

    task automatic test_random_traffic();
        logic [63:0] exc_d;
        logic [63:0] irq_d;
        logic [63:0] mvec;
        logic [63:0] svec;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    exc_d = '0; irq_d = '0; mvec = '0; svec = '0;
                end
                1: begin
                    exc_d = '1; irq_d = '1; mvec = '1; svec = '1;
                end
                2: begin
                    // Vectored bases at the top of the address space wrap on the add.
                    exc_d = '0; irq_d = '1;
                    mvec = {62'h3FFF_FFFF_FFFF_FFFF, VEC_VECTORED};
                    svec = {62'h3FFF_FFFF_FFFF_FFFF, VEC_VECTORED};
                end
                default: begin
                    exc_d = {$urandom, $urandom};
                    irq_d = {$urandom, $urandom};
                    mvec  = {$urandom, $urandom};
                    svec  = {$urandom, $urandom};
                end
            endcase
            drain();
            set_config(exc_d, irq_d, mvec, svec);
            repeat (85) send_word(random_word());
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_item     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_EXC_DELEG;
        i_cfg_data <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_full_delegation();
        test_interrupt_priority();
        test_random_traffic();
        drain();

        if (error_count == 0 && trap_decisions_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
